// File: src/bfa_pkg.sv
// Shared constants, codes and controller/datapath types for the bitmap allocator.
`default_nettype none

package bfa_pkg;

    // Field widths of the request and response transactions
    localparam int NUM_W  = 14;
    localparam int STAT_W = 2;

    // Configuration port geometry
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register index decoded from paddr[2]
    localparam logic REG_POOL_LIMIT = 1'b0;

    // Pool limit after reset
    localparam logic [NUM_W-1:0] LIMIT_RESET = 14'd8192;

    // Request commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Response status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr;   // zero one bitmap word of the clearing pass
        logic load;  // take a request and restart the word walk
        logic scan;  // issue one read and evaluate the previous word
        logic push;  // move the finished result into the output register
    } t_ctrl_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;  // current clearing write hits the last word
        logic done;      // the request being worked on is resolved
        logic out_free;  // output register can take a result this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

// File: src/bfa_if.sv
// Request and response channel interfaces of the bitmap allocator.
`default_nettype none

interface bfa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [bfa_pkg::NUM_W-1:0]     object_number;

    modport source (output valid, output command, output object_number, input ready);
    modport sink   (input valid, input command, input object_number, output ready);
endinterface

interface bfa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bfa_pkg::NUM_W-1:0]     granted_number;
    logic [bfa_pkg::STAT_W-1:0]    status;
    logic [bfa_pkg::NUM_W-1:0]     free_count;

    modport source (output valid, output granted_number, output status, output free_count,
                    input ready);
    modport sink   (input valid, input granted_number, input status, input free_count,
                    output ready);
endinterface

`default_nettype wire

// File: src/bfa_ctrl.sv
// Controller state machine: clearing pass, request accept, word walk and result hand-off.
`default_nettype none

module bfa_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire bfa_pkg::t_dp_sts i_sts,
    output bfa_pkg::t_ctrl_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    // Decode datapath commands from the current state
    always_comb begin
        o_cmd      = '0;
        o_cmd.clr  = (r_state == S_CLEAR);
        o_cmd.load = (r_state == S_IDLE) && r_in_ready && i_in_valid;
        o_cmd.scan = (r_state == S_SCAN);
        o_cmd.push = (r_state == S_DONE) && i_sts.out_free;
    end

    assign o_in_ready = r_in_ready;

    // State and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_in_ready <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_state    <= S_SCAN;
                        r_in_ready <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (i_sts.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_sts.out_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_CLEAR;
                    r_in_ready <= 1'b0;
                end
            endcase
        end
    end

    // Ready only ever shows in the idle state
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> (r_state == S_IDLE))
        else $error("ready raised outside idle");

    // Clearing pass keeps requests out until its last word is written
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.clr && !i_sts.clr_last) |=> !r_in_ready)
        else $error("request accepted during clearing pass");

    // A resolved request always reaches the hand-off state
    a_scan_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.scan && i_sts.done) |=> (r_state == S_DONE))
        else $error("resolved request did not reach hand-off");

endmodule

`default_nettype wire

// File: src/bfa_dpath.sv
// Datapath: bitmap memory, word walk, first-clear search, free counter, limit register, output.
`default_nettype none

module bfa_dpath #(
    parameter int POOL_SIZE = 8192,
    parameter int WORD_BITS = 64
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire bfa_pkg::t_ctrl_cmd          i_cmd,
    output bfa_pkg::t_dp_sts                 o_sts,
    // request payload
    input  wire                              i_command,
    input  wire  [bfa_pkg::NUM_W-1:0]        i_object_number,
    // response
    output logic                             o_rsp_valid,
    input  wire                              i_rsp_ready,
    output logic [bfa_pkg::NUM_W-1:0]        o_granted_number,
    output logic [bfa_pkg::STAT_W-1:0]       o_status,
    output logic [bfa_pkg::NUM_W-1:0]        o_free_count,
    // configuration
    input  wire                              i_cfg_we,
    input  wire                              i_cfg_sel,
    input  wire  [bfa_pkg::APB_DW-1:0]       i_cfg_wdata,
    output logic [bfa_pkg::APB_DW-1:0]       o_cfg_rdata
);

    localparam int NUM_WORDS = (POOL_SIZE + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int BASE_RAW  = $clog2(NUM_WORDS * WORD_BITS + WORD_BITS + 1);
    localparam int BASE_W    = (BASE_RAW > bfa_pkg::NUM_W + 1) ? BASE_RAW : bfa_pkg::NUM_W + 1;
    localparam logic [AW-1:0]     LAST_ADDR = AW'(NUM_WORDS - 1);
    localparam logic [BASE_W-1:0] STEP      = BASE_W'(WORD_BITS);

    // Clamp a limit value to the pool size
    function automatic logic [BASE_W-1:0] eff_limit(input logic [bfa_pkg::NUM_W-1:0] v);
        logic [BASE_W-1:0] vw;
        vw = BASE_W'(v);
        eff_limit = (vw > BASE_W'(POOL_SIZE)) ? BASE_W'(POOL_SIZE) : vw;
    endfunction

    // Bitmap memory
    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    // Registers
    logic [bfa_pkg::NUM_W-1:0]  r_limit;
    logic [bfa_pkg::NUM_W-1:0]  r_free;
    logic                       r_cmd;
    logic [bfa_pkg::NUM_W-1:0]  r_num;
    logic                       r_bad;
    logic [AW-1:0]              r_addr;
    logic [BASE_W-1:0]          r_base;
    logic [AW-1:0]              r_ev_addr;
    logic [BASE_W-1:0]          r_ev_base;
    logic                       r_ev_vld;
    logic [bfa_pkg::NUM_W-1:0]  r_res_granted;
    logic [bfa_pkg::STAT_W-1:0] r_res_status;
    logic                       r_out_vld;
    logic [bfa_pkg::NUM_W-1:0]  r_out_granted;
    logic [bfa_pkg::STAT_W-1:0] r_out_status;
    logic [bfa_pkg::NUM_W-1:0]  r_out_free;

    // Combinational
    logic [BASE_W-1:0]          w_lim;
    logic [BASE_W-1:0]          w_rem;
    logic [BASE_W-1:0]          w_u;
    logic [WORD_BITS-1:0]       w_mask;
    logic [WORD_BITS-1:0]       w_clear;
    logic [BW-1:0]              w_pe;
    logic [BW-1:0]              w_bit;
    logic [WORD_BITS-1:0]       w_sel;
    logic                       w_done;
    logic                       w_found;
    logic                       w_freeing;
    logic [bfa_pkg::STAT_W-1:0] w_status;
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [WORD_BITS-1:0]       w_wdata;
    logic [bfa_pkg::NUM_W-1:0]  n_free;
    logic [BASE_W-1:0]          w_granted;

    assign w_lim = eff_limit(r_limit);
    assign w_rem = w_lim - r_ev_base;
    assign w_u   = BASE_W'(r_num) - BASE_W'(1);

    // Mask off bits at or above the limit, then find the lowest clear bit
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            w_mask[b] = (BASE_W'(b) < w_rem);
        end
        w_clear = ~r_rdata & w_mask;
        w_pe    = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (w_clear[b]) begin
                w_pe = BW'(b);
            end
        end
    end

    // Bit position of the number to free within the word under evaluation
    assign w_bit = w_u[BW-1:0] - r_ev_base[BW-1:0];

    // Resolve the request against the word under evaluation
    always_comb begin
        w_done    = 1'b0;
        w_found   = 1'b0;
        w_freeing = 1'b0;
        w_status  = bfa_pkg::ST_OK;
        if (r_bad) begin
            w_done   = 1'b1;
            w_status = bfa_pkg::ST_RANGE;
        end else if (r_ev_vld) begin
            if (r_cmd == bfa_pkg::CMD_ALLOC) begin
                if (r_ev_base >= w_lim) begin
                    w_done   = 1'b1;
                    w_status = bfa_pkg::ST_FULL;
                end else if (|w_clear) begin
                    w_done  = 1'b1;
                    w_found = 1'b1;
                end
            end else if (w_u < r_ev_base + STEP) begin
                w_done    = 1'b1;
                w_freeing = 1'b1;
            end
        end
    end

    assign w_sel     = WORD_BITS'(1) << (w_found ? w_pe : w_bit);
    assign w_granted = r_ev_base + BASE_W'(w_pe) + BASE_W'(1);

    // Memory write: clearing pass or bit update
    always_comb begin
        w_we    = i_cmd.clr || (i_cmd.scan && (w_found || w_freeing));
        w_waddr = i_cmd.clr ? r_addr : r_ev_addr;
        if (i_cmd.clr) begin
            w_wdata = '0;
        end else if (w_found) begin
            w_wdata = r_rdata | w_sel;
        end else begin
            w_wdata = r_rdata & ~w_sel;
        end
    end

    // Next free count after a resolved request
    always_comb begin
        n_free = r_free;
        if (w_found && (r_free != '0)) begin
            n_free = r_free - bfa_pkg::NUM_W'(1);
        end else if (w_freeing && (BASE_W'(r_free) < w_lim)) begin
            n_free = r_free + bfa_pkg::NUM_W'(1);
        end
    end

    // Bitmap storage with registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[r_addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= bfa_pkg::LIMIT_RESET;
            r_free    <= bfa_pkg::NUM_W'(eff_limit(bfa_pkg::LIMIT_RESET));
            r_addr    <= '0;
            r_base    <= '0;
            r_ev_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // limit write reloads the counter
            if (i_cfg_we && (i_cfg_sel == bfa_pkg::REG_POOL_LIMIT)) begin
                r_limit <= i_cfg_wdata[bfa_pkg::NUM_W-1:0];
                r_free  <= bfa_pkg::NUM_W'(eff_limit(i_cfg_wdata[bfa_pkg::NUM_W-1:0]));
            end else if (i_cmd.scan && w_done) begin
                r_free <= n_free;
            end
            // walk pointers
            if (i_cmd.load) begin
                r_addr   <= '0;
                r_base   <= '0;
                r_ev_vld <= 1'b0;
            end else if (i_cmd.clr || i_cmd.scan) begin
                if (r_addr != LAST_ADDR) begin
                    r_addr <= r_addr + AW'(1);
                end
                r_base   <= r_base + STEP;
                r_ev_vld <= i_cmd.scan;
            end
            // output register
            if (i_cmd.push) begin
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_num <= i_object_number;
            r_bad <= (i_command == bfa_pkg::CMD_FREE) &&
                     ((i_object_number == '0) || (BASE_W'(i_object_number) > w_lim));
        end
        if (i_cmd.scan) begin
            r_ev_addr <= r_addr;
            r_ev_base <= r_base;
        end
        if (i_cmd.scan && w_done) begin
            r_res_granted <= w_found ? bfa_pkg::NUM_W'(w_granted) : '0;
            r_res_status  <= w_status;
        end
        if (i_cmd.push) begin
            r_out_granted <= r_res_granted;
            r_out_status  <= r_res_status;
            r_out_free    <= r_free;
        end
    end

    // Status to the controller
    always_comb begin
        o_sts          = '0;
        o_sts.clr_last = i_cmd.clr && (r_addr == LAST_ADDR);
        o_sts.done     = w_done;
        o_sts.out_free = !r_out_vld || i_rsp_ready;
    end

    assign o_rsp_valid      = r_out_vld;
    assign o_granted_number = r_out_granted;
    assign o_status         = r_out_status;
    assign o_free_count     = r_out_free;
    assign o_cfg_rdata      = (i_cfg_sel == bfa_pkg::REG_POOL_LIMIT) ?
                              bfa_pkg::APB_DW'(r_limit) : '0;

    // Counter never climbs above the effective limit
    a_free_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        BASE_W'(r_free) <= w_lim)
        else $error("free counter above limit");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_rsp_ready) |-> !i_cmd.push)
        else $error("result overwritten before it was taken");

    // A nonzero grant only comes with status ok
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_out_status == bfa_pkg::ST_OK) || (r_out_granted == '0)))
        else $error("grant reported with failing status");

    // Memory is only written by the clearing pass or a resolved request
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (i_cmd.clr || (i_cmd.scan && w_done)))
        else $error("stray bitmap write");

endmodule

`default_nettype wire

// File: src/bitmap_first_fit_allocator.sv
// Walk: once a request is accepted, bitmap words are read one per cycle through the single
//   memory read port until it resolves; a full pool reads every word below the limit plus one
//   more (129 words by default); an out-of-range free resolves before any word is evaluated.
// Flow: one transaction at a time; the next request can be accepted in the cycle after the
//   result moves to the output register, which holds it until the response is taken.
// Reset: synchronous, active low; a clearing pass then zeroes one bitmap word per cycle with
//   no request accepted; configuration writes are taken throughout.
`default_nettype none

module bitmap_first_fit_allocator #(
    parameter int POOL_SIZE = 8192,
    parameter int WORD_BITS = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    bfa_req_if.sink                      i_req,
    bfa_rsp_if.source                    o_rsp,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [bfa_pkg::APB_AW-1:0]   paddr,
    input  wire  [bfa_pkg::APB_DW-1:0]   pwdata,
    output logic [bfa_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    bfa_pkg::t_ctrl_cmd w_cmd;
    bfa_pkg::t_dp_sts   w_sts;
    logic               w_cfg_we;

    // Write completes on the access phase; no wait states
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    bfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bfa_dpath #(
        .POOL_SIZE (POOL_SIZE),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_command        (i_req.command),
        .i_object_number  (i_req.object_number),
        .o_rsp_valid      (o_rsp.valid),
        .i_rsp_ready      (o_rsp.ready),
        .o_granted_number (o_rsp.granted_number),
        .o_status         (o_rsp.status),
        .o_free_count     (o_rsp.free_count),
        .i_cfg_we         (w_cfg_we),
        .i_cfg_sel        (paddr[2]),
        .i_cfg_wdata      (pwdata),
        .o_cfg_rdata      (prdata)
    );

endmodule

`default_nettype wire
